@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ hw/rtl/pctc_pkg.sv @@
// ----------------------------------------------------------------------------
// pctc_pkg
// Types and constant tables of the permutation cycle type classifier.
// ----------------------------------------------------------------------------
package pctc_pkg;

	localparam int NPTS   = 10;   // points per permutation
	localparam int NTYPES = 7;    // matched cycle types
	localparam int NLEN   = 5;    // even cycle lengths 2,4,6,8,10

	typedef logic [3:0] pt_t;
	typedef logic [2:0] code_t;

	localparam code_t NO_MATCH = 3'd7;

	// one pipeline beat: both permutations plus the per-point walk state
	typedef struct packed {
		logic                ok;     // input is a true permutation
		pt_t                 first;  // raw image of point 0
		pt_t [NPTS-1:0]      lp;     // candidate
		pt_t [NPTS-1:0]      rp;     // candidate composed with root inverse
		pt_t [NPTS-1:0]      lcur;   // current position of each lane's walk
		pt_t [NPTS-1:0]      rcur;
		pt_t [NPTS-1:0]      llen;   // cycle length found, 0 = not yet
		pt_t [NPTS-1:0]      rlen;
	} lane_st_t;

	// inverse of each root representative; last row (code 7) is identity
	localparam pt_t ROOT_INV [8][NPTS] = '{
		'{4'd9, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8},
		'{4'd1, 4'd0, 4'd3, 4'd2, 4'd5, 4'd4, 4'd7, 4'd6, 4'd9, 4'd8},
		'{4'd3, 4'd0, 4'd1, 4'd2, 4'd5, 4'd4, 4'd7, 4'd6, 4'd9, 4'd8},
		'{4'd3, 4'd0, 4'd1, 4'd2, 4'd7, 4'd4, 4'd5, 4'd6, 4'd9, 4'd8},
		'{4'd5, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd7, 4'd6, 4'd9, 4'd8},
		'{4'd5, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd9, 4'd6, 4'd7, 4'd8},
		'{4'd7, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd9, 4'd8},
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9}
	};

	// points lying on cycles of length 2,4,6,8,10 for each type
	localparam pt_t TYPE_CNT [NTYPES][NLEN] = '{
		'{4'd0,  4'd0, 4'd0, 4'd0, 4'd10},
		'{4'd10, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd6,  4'd4, 4'd0, 4'd0, 4'd0},
		'{4'd2,  4'd8, 4'd0, 4'd0, 4'd0},
		'{4'd4,  4'd0, 4'd6, 4'd0, 4'd0},
		'{4'd0,  4'd4, 4'd6, 4'd0, 4'd0},
		'{4'd2,  4'd0, 4'd0, 4'd8, 4'd0}
	};

endpackage

@@ hw/rtl/pctc_front.sv @@
// ----------------------------------------------------------------------------
// pctc_front
// Checks the input is a permutation, forms the product with the root
// inverse and seeds every lane's walk at its own point.
// ----------------------------------------------------------------------------
module pctc_front import pctc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  pt_t [NPTS-1:0] img,
	input  code_t          root_sel,
	output logic           out_vld,
	output lane_st_t       out_st
);

	logic     ok;
	lane_st_t st_d;
	logic     vld_s1;
	lane_st_t st_s1;

	// permutation check: range and pairwise distinct
	always_comb begin
		ok = 1'b1;
		for (int i = 0; i < NPTS; i++) begin
			if (img[i] > 4'd9) ok = 1'b0;
			for (int j = i + 1; j < NPTS; j++) begin
				if (img[i] == img[j]) ok = 1'b0;
			end
		end
	end

	// product and lane seeds
	always_comb begin
		st_d.ok    = ok;
		st_d.first = img[0];
		st_d.lp    = img;
		for (int p = 0; p < NPTS; p++) begin
			st_d.rp[p]   = img[ROOT_INV[root_sel][p]];
			st_d.lcur[p] = pt_t'(p);
			st_d.rcur[p] = pt_t'(p);
			st_d.llen[p] = 4'd0;
			st_d.rlen[p] = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st_d;
		end
	end

	assign out_vld = vld_s1;
	assign out_st  = st_s1;

endmodule

@@ hw/rtl/pctc_step.sv @@
// ----------------------------------------------------------------------------
// pctc_step
// One walk step for all lanes of both permutations: each lane moves to the
// image of its current point and records STEP when it is back at its start.
// ----------------------------------------------------------------------------
module pctc_step import pctc_pkg::*; #(
	parameter int STEP = 1
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_vld,
	input  lane_st_t in_st,
	output logic     out_vld,
	output lane_st_t out_st
);

	lane_st_t st_d;
	logic     vld_s1;
	lane_st_t st_s1;

	// ten independent lanes per permutation
	always_comb begin
		st_d = in_st;
		for (int i = 0; i < NPTS; i++) begin
			st_d.lcur[i] = in_st.lp[in_st.lcur[i]];
			st_d.rcur[i] = in_st.rp[in_st.rcur[i]];
			if (in_st.llen[i] == 4'd0 && st_d.lcur[i] == pt_t'(i)) st_d.llen[i] = pt_t'(STEP);
			if (in_st.rlen[i] == 4'd0 && st_d.rcur[i] == pt_t'(i)) st_d.rlen[i] = pt_t'(STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st_d;
		end
	end

	assign out_vld = vld_s1;
	assign out_st  = st_s1;

endmodule

@@ hw/rtl/pctc_merge.sv @@
// ----------------------------------------------------------------------------
// pctc_merge
// Combines the lane cycle lengths into per-length point counts, matches
// them against the type table and holds the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pctc_merge import pctc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_vld,
	input  lane_st_t in_st,
	output logic     out_vld,
	output code_t    cand_code,
	output code_t    prod_code,
	output pt_t      first_image
);

	code_t lcode, rcode;
	logic  all_found;
	logic  vld_q;
	code_t left_q, right_q;
	pt_t   first_q;

	// count points per even cycle length, then look up the type
	function automatic code_t classify(input pt_t [NPTS-1:0] len);
		pt_t   cnt [NLEN];
		code_t code;
		logic  hit;
		code = NO_MATCH;
		for (int l = 0; l < NLEN; l++) begin
			cnt[l] = 4'd0;
			for (int i = 0; i < NPTS; i++) begin
				if (len[i] == pt_t'(2 * l + 2)) cnt[l] = cnt[l] + 4'd1;
			end
		end
		for (int t = 0; t < NTYPES; t++) begin
			hit = 1'b1;
			for (int l = 0; l < NLEN; l++) begin
				if (cnt[l] != TYPE_CNT[t][l]) hit = 1'b0;
			end
			if (hit && code == NO_MATCH) code = code_t'(t);
		end
		return code;
	endfunction

	always_comb begin
		lcode = in_st.ok ? classify(in_st.llen) : NO_MATCH;
		rcode = in_st.ok ? classify(in_st.rlen) : NO_MATCH;
	end

	// every lane of a true permutation closes its cycle within ten steps
	always_comb begin
		all_found = 1'b1;
		for (int i = 0; i < NPTS; i++) begin
			if (in_st.llen[i] == 4'd0 || in_st.rlen[i] == 4'd0) all_found = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_q  <= lcode;
			right_q <= rcode;
			first_q <= in_st.first;
		end
	end

	assign out_vld     = vld_q;
	assign cand_code   = left_q;
	assign prod_code   = right_q;
	assign first_image = first_q;

	`ASSERT_AT(a_lanes_closed, clk, arst_n, in_vld && in_st.ok |-> all_found, "lane cycle not closed")

endmodule

@@ hw/rtl/permutation_cycle_type_classifier_core.sv @@
// ----------------------------------------------------------------------------
// permutation_cycle_type_classifier_core
// Cycle type classifier for permutations of ten points, with root product.
// ----------------------------------------------------------------------------
// Takes one permutation per cycle and returns one result beat per input beat:
// the front register holds the permutation check and the product with the root
// inverse, then one walk step per possible cycle length follows (ten lanes per
// permutation), and the merge register counts lengths and matches the seven
// types. A stalled output holds the whole pipeline; otherwise a beat is
// accepted every cycle. Inputs that are not permutations give type code 7 on
// both outputs. Write the root type register only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module permutation_cycle_type_classifier_core import pctc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic [3:0] image_of_0,
	input  logic [3:0] image_of_1,
	input  logic [3:0] image_of_2,
	input  logic [3:0] image_of_3,
	input  logic [3:0] image_of_4,
	input  logic [3:0] image_of_5,
	input  logic [3:0] image_of_6,
	input  logic [3:0] image_of_7,
	input  logic [3:0] image_of_8,
	input  logic [3:0] image_of_9,
	output logic  out_valid,
	input  logic  out_ready,
	output logic [2:0] cand_code,
	output logic [2:0] prod_code,
	output logic [3:0] first_image
);

	code_t          root_sel_q;
	logic           adv;
	pt_t [NPTS-1:0] img;
	logic           vld [NPTS+1];
	lane_st_t       st  [NPTS+1];

	// root type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_sel_q <= 3'd0;
		end else if (cfg_wr_en) begin
			root_sel_q <= cfg_wr_data;
		end
	end

	// pipeline moves whenever the output slot is free or being taken
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	assign img = {image_of_9, image_of_8, image_of_7, image_of_6, image_of_5,
		image_of_4, image_of_3, image_of_2, image_of_1, image_of_0};

	pctc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (in_valid),
		.img      (img),
		.root_sel (root_sel_q),
		.out_vld  (vld[0]),
		.out_st   (st[0])
	);

	// walk steps 1..10
	for (genvar k = 0; k < NPTS; k++) begin : g_step
		pctc_step #(.STEP(k + 1)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.in_vld  (vld[k]),
			.in_st   (st[k]),
			.out_vld (vld[k+1]),
			.out_st  (st[k+1])
		);
	end

	pctc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_vld      (vld[NPTS]),
		.in_st       (st[NPTS]),
		.out_vld     (out_valid),
		.cand_code   (cand_code),
		.prod_code   (prod_code),
		.first_image (first_image)
	);

	`ASSERT_AT(a_accept_enters, clk, arst_n, in_valid && in_ready |=> vld[0], "beat lost at entry")
	`ASSERT_NEVER(a_type_img, clk, arst_n, out_valid && cand_code != NO_MATCH && first_image > 4'd9, "bad image")

endmodule
